/* rtl/mse_pkg.sv */
`default_nettype none
package mse_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CW = 33;
  localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;
  localparam logic [15:0] RADIUS_RESET = 16'd4096;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    cval_t ux;
    cval_t uy;
    cval_t uz;
    cval_t hx;
    cval_t hy;
    cval_t hz;
    logic uflip;
    logic hflip;
    logic signed [15:0] v;
  } cord_t;

  function automatic cval_t atan_turn(input int i);
    cval_t r;
    r = '0;
    case (i)
      0: r = 33'sd536870912;
      1: r = 33'sd316933406;
      2: r = 33'sd167458907;
      3: r = 33'sd85004756;
      4: r = 33'sd42667331;
      5: r = 33'sd21354465;
      6: r = 33'sd10679838;
      7: r = 33'sd5340245;
      8: r = 33'sd2670163;
      9: r = 33'sd1335087;
      10: r = 33'sd667544;
      11: r = 33'sd333772;
      12: r = 33'sd166886;
      13: r = 33'sd83443;
      14: r = 33'sd41721;
      15: r = 33'sd20860;
      16: r = 33'sd10430;
      17: r = 33'sd5215;
      18: r = 33'sd2607;
      19: r = 33'sd1303;
      20: r = 33'sd651;
      21: r = 33'sd325;
      22: r = 33'sd162;
      23: r = 33'sd81;
      24: r = 33'sd40;
      25: r = 33'sd20;
      26: r = 33'sd10;
      27: r = 33'sd5;
      28: r = 33'sd2;
      29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // fold second and third quadrant onto the right half plane
  function automatic logic phase_flip(input logic [31:0] p);
    return p[31] ^ p[30];
  endfunction

  function automatic cval_t phase_resid(input logic [31:0] p);
    logic [31:0] q;
    q = p ^ {phase_flip(p), 31'b0};
    return cval_t'(signed'({q[31], q}));
  endfunction

endpackage
`default_nettype wire

/* rtl/mse_ifs.sv */
`default_nettype none
interface mse_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] angle_u;
  logic signed [15:0] offset_v;
  modport source (output valid, output angle_u, output offset_v, input ready);
  modport sink (input valid, input angle_u, input offset_v, output ready);
endinterface

interface mse_out_if;
  logic valid;
  logic ready;
  logic signed [18:0] pos_x;
  logic signed [18:0] pos_y;
  logic signed [15:0] pos_z;
  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface mse_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/mse_cordic_stage.sv */
`default_nettype none
module mse_cordic_stage #(
  parameter int STEP = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           valid_in,
  input  wire mse_pkg::cord_t d_in,
  output logic                valid_out,
  output mse_pkg::cord_t      d_out
);
  import mse_pkg::*;

  cord_t d_next;
  cval_t at;

  always_comb begin
    at = atan_turn(STEP);
    d_next = d_in;
    if (!d_in.uz[CW-1]) begin
      d_next.ux = d_in.ux - (d_in.uy >>> STEP);
      d_next.uy = d_in.uy + (d_in.ux >>> STEP);
      d_next.uz = d_in.uz - at;
    end else begin
      d_next.ux = d_in.ux + (d_in.uy >>> STEP);
      d_next.uy = d_in.uy - (d_in.ux >>> STEP);
      d_next.uz = d_in.uz + at;
    end
    if (!d_in.hz[CW-1]) begin
      d_next.hx = d_in.hx - (d_in.hy >>> STEP);
      d_next.hy = d_in.hy + (d_in.hx >>> STEP);
      d_next.hz = d_in.hz - at;
    end else begin
      d_next.hx = d_in.hx + (d_in.hy >>> STEP);
      d_next.hy = d_in.hy - (d_in.hx >>> STEP);
      d_next.hz = d_in.hz + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end
endmodule
`default_nettype wire

/* rtl/mse_post.sv */
`default_nettype none
module mse_post (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               valid_in,
  input  wire mse_pkg::cord_t     d_in,
  input  wire logic [15:0]        radius,
  output logic                    valid_out,
  output logic signed [18:0]      x,
  output logic signed [18:0]      y,
  output logic signed [15:0]      z
);
  import mse_pkg::*;

  localparam logic signed [53:0] HALF = 54'sd536870912;

  logic signed [31:0] cu, su, ch, sh;
  logic signed [31:0] a_cu, a_su, b_cu, b_su;
  logic signed [47:0] a_pch, a_psh;
  logic signed [18:0] b_r;
  logic signed [15:0] b_z, c_z;
  logic signed [50:0] c_px, c_py;
  logic [2:0] vld;
  logic signed [53:0] rch, rsh, rx, ry;

  always_comb begin
    cu = d_in.uflip ? 32'(-d_in.ux) : d_in.ux[31:0];
    su = d_in.uflip ? 32'(-d_in.uy) : d_in.uy[31:0];
    ch = d_in.hflip ? 32'(-d_in.hx) : d_in.hx[31:0];
    sh = d_in.hflip ? 32'(-d_in.hy) : d_in.hy[31:0];
    rch = (54'(a_pch) + HALF) >>> 30;
    rsh = (54'(a_psh) + HALF) >>> 30;
    rx = (54'(c_px) + HALF) >>> 30;
    ry = (54'(c_py) + HALF) >>> 30;
  end

  function automatic logic signed [18:0] sat19(input logic signed [53:0] w);
    if (w > 54'sd262143) return 19'sd262143;
    if (w < -54'sd262144) return -19'sd262144;
    return w[18:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [53:0] w);
    if (w > 54'sd32767) return 16'sd32767;
    if (w < -54'sd32768) return -16'sd32768;
    return w[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      valid_out <= 1'b0;
    end else if (en) begin
      vld <= {vld[1:0], valid_in};
      valid_out <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pch <= d_in.v * ch;
      a_psh <= d_in.v * sh;
      a_cu <= cu;
      a_su <= su;
      b_r <= signed'({3'b0, radius}) + rch[18:0];
      b_z <= sat16(rsh);
      b_cu <= a_cu;
      b_su <= a_su;
      c_px <= b_r * b_cu;
      c_py <= b_r * b_su;
      c_z <= b_z;
      x <= sat19(rx);
      y <= sat19(ry);
      z <= c_z;
    end
  end
endmodule
`default_nettype wire

/* rtl/mobius_strip_embedding_top.sv */
`default_nettype none
// Mobius strip embedding: each word (angle_u, offset_v) gives pos_x, pos_y, pos_z with
// R = strip_radius + v*cos(u/2), x = R*cos(u), y = R*sin(u), z = v*sin(u/2), all
// 12 fractional bits, saturated. One word per cycle is taken. Stages: one phase setup,
// 30 CORDIC (one rotation step each, both angles in parallel) and four multiply, round
// and saturate. The whole pipeline holds while a result waits downstream. The user
// must write strip_radius on cfg only while idle; the block does not enforce it.
module mobius_strip_embedding_top #(
  parameter int ANGLE_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  mse_in_if.sink   in_ch,
  mse_out_if.source out_ch,
  mse_cfg_if.sink  cfg
);
  import mse_pkg::*;

  localparam logic [31:0] QMASK = ~(32'hFFFF_FFFF >> (ANGLE_BITS + 1));

  logic en;
  logic [15:0] radius;
  logic [31:0] phu, phh;
  logic v0;
  cord_t d0;
  logic [CORDIC_STEPS:0] sv;
  cord_t sd [CORDIC_STEPS+1];

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.data;
    end
  end

  always_comb begin
    phu = {in_ch.angle_u, 16'b0} & QMASK;
    phh = {in_ch.angle_u[15], in_ch.angle_u, 15'b0} & QMASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0.ux <= CORDIC_START;
      d0.uy <= '0;
      d0.uz <= phase_resid(phu);
      d0.uflip <= phase_flip(phu);
      d0.hx <= CORDIC_START;
      d0.hy <= '0;
      d0.hz <= phase_resid(phh);
      d0.hflip <= phase_flip(phh);
      d0.v <= in_ch.offset_v;
    end
  end

  assign sv[0] = v0;
  assign sd[0] = d0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    mse_cordic_stage #(.STEP(i)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(sv[i]), .d_in(sd[i]),
      .valid_out(sv[i+1]), .d_out(sd[i+1])
    );
  end

  mse_post u_post (
    .clk(clk), .rst(rst), .en(en),
    .valid_in(sv[CORDIC_STEPS]), .d_in(sd[CORDIC_STEPS]),
    .radius(radius),
    .valid_out(out_ch.valid),
    .x(out_ch.pos_x), .y(out_ch.pos_y), .z(out_ch.pos_z)
  );
endmodule
`default_nettype wire

/* rtl/mse_checker.sv */
`default_nettype none
module mse_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cfg_ready,
  input wire logic [53:0] out_word
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");
endmodule

bind mobius_strip_embedding_top mse_checker u_mse_checker (
  .clk(clk), .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .cfg_ready(cfg.ready),
  .out_word({out_ch.pos_x, out_ch.pos_y, out_ch.pos_z})
);
`default_nettype wire
